@@ src/bine_pkg.sv @@
// shared types and constants for the b+ tree internal node engine
// no dependencies; compiled first

package bine_pkg;

   localparam int KEY_W   = 64;
   localparam int CHILD_W = 32;
   localparam int ACT_W   = 3;
   localparam int STS_W   = 2;

   typedef logic [ACT_W-1:0] action_type;
   typedef logic [STS_W-1:0] status_type;

   // operation codes
   localparam action_type ACT_CLEAR    = 3'd0;
   localparam action_type ACT_SET_LEFT = 3'd1;
   localparam action_type ACT_FIND     = 3'd2;
   localparam action_type ACT_INSERT   = 3'd3;
   localparam action_type ACT_SPLIT    = 3'd4;

   // status codes
   localparam status_type STS_OK    = 2'd0;
   localparam status_type STS_FULL  = 2'd1;
   localparam status_type STS_EMPTY = 2'd2;

   typedef struct packed {
      action_type         action;
      logic [KEY_W-1:0]   key;
      logic [CHILD_W-1:0] child;
   } req_payload_type;

   typedef struct packed {
      status_type         status;
      logic [CHILD_W-1:0] child_out;
      logic [KEY_W-1:0]   key_out;
      logic               last;
   } rsp_payload_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic               ins_en;
      logic [KEY_W-1:0]   key;
      logic [CHILD_W-1:0] child;
   } cell_ctl_type;

   // what a cell hands to its right neighbor
   typedef struct packed {
      logic               lt;
      logic [KEY_W-1:0]   key;
      logic [CHILD_W-1:0] child;
   } nbr_type;

   // search token travelling down the row
   typedef struct packed {
      logic               valid;
      logic               found;
      logic [CHILD_W-1:0] sel;
   } tok_type;

endpackage

@@ src/bine_if.sv @@
// valid/ready channel interfaces for request and response beats
// depends on bine_pkg

interface bine_req_if;
   import bine_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface bine_rsp_if;
   import bine_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ src/bine_cell.sv @@
// one slot of the node: a key and the child to its right
// depends on bine_pkg

module bine_cell
   import bine_pkg::*;
#(
   parameter int CELL_IDX_P = 0,
   parameter int CNT_W_P    = 5
) (
   input  logic               clock,
   input  logic               reset,
   input  cell_ctl_type       ctl,
   input  logic [CNT_W_P-1:0] count,
   input  nbr_type            nbr_in,
   output nbr_type            nbr_out,
   input  tok_type            tok_in,
   output tok_type            tok_out
);

   localparam logic [CNT_W_P-1:0] MY_IDX = CNT_W_P'(CELL_IDX_P);

   logic [KEY_W-1:0]   key_ff, key_in;
   logic [CHILD_W-1:0] child_ff, child_in;
   tok_type            tok_ff, tok_in_next;
   logic               in_use, in_reach, lt, hit;

   assign in_use   = MY_IDX < count;
   assign in_reach = MY_IDX <= count;
   assign lt       = in_use && (key_ff < ctl.key);
   // first key above the probe, or past the used slots
   assign hit      = !tok_in.found && (!in_use || (ctl.key < key_ff));

   always_comb begin
      key_in   = key_ff;
      child_in = child_ff;
      // at or right of the insert point: take the new entry or shift right
      if (ctl.ins_en && in_reach && !lt) begin
         if (nbr_in.lt) begin
            key_in   = ctl.key;
            child_in = ctl.child;
         end else begin
            key_in   = nbr_in.key;
            child_in = nbr_in.child;
         end
      end
   end

   always_comb begin
      tok_in_next.valid = tok_in.valid;
      tok_in_next.found = tok_in.found | hit;
      tok_in_next.sel   = hit ? nbr_in.child : tok_in.sel;
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      child_ff <= child_in;
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_next;
      end
   end

   assign nbr_out.lt    = lt;
   assign nbr_out.key   = key_ff;
   assign nbr_out.child = child_ff;
   assign tok_out       = tok_ff;

endmodule

@@ src/btree_internal_node_engine_unit.sv @@
// b+ tree internal node engine (uses bine_pkg, bine_if, bine_cell)
// clear, set, refused insert and empty split answer from idle; insert passes through ST_INS;
// find waits for the probe walking one cell per cycle; split streams one beat per cycle
// one operation at a time: a result waiting on the consumer holds off the next accept
// and paces the split stream
// reset (synchronous, active high) empties the node; slot contents stay undefined

module btree_internal_node_engine_unit
   import bine_pkg::*;
#(
   parameter int MAX_KEYS_P = 16
) (
   input  logic          clock,
   input  logic          reset,
   bine_req_if.sink      req_chan,
   bine_rsp_if.source    rsp_chan
);

   localparam int CNT_W = $clog2(MAX_KEYS_P + 1);
   localparam int IDX_W = $clog2(MAX_KEYS_P);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_KEYS_P);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_INS   = 4'b0010,
      ST_FIND  = 4'b0100,
      ST_SPLIT = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   key_total_ff, key_total_in;
   logic [CHILD_W-1:0] child0_ff, child0_in;
   logic [KEY_W-1:0]   op_key_ff, op_key_in;
   logic [CHILD_W-1:0] op_child_ff, op_child_in;
   logic               start_ff, start_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_data_ff, rsp_data_in;

   logic               req_accept;
   logic               rsp_free;
   logic               rsp_load;
   rsp_payload_type    rsp_next;
   logic               ins_en;
   logic [CNT_W-1:0]   rd_sel;
   logic               split_last;
   cell_ctl_type       cell_ctl;

   // element 0 is a virtual slot left of the row: below every key, holds child 0
   nbr_type nbr_chain [MAX_KEYS_P+1];
   tok_type tok_chain [MAX_KEYS_P+1];

   assign nbr_chain[0].lt    = 1'b1;
   assign nbr_chain[0].key   = '0;
   assign nbr_chain[0].child = child0_ff;

   // a search token enters the row the cycle after a find is accepted
   assign tok_chain[0].valid = start_ff;
   assign tok_chain[0].found = 1'b0;
   assign tok_chain[0].sel   = '0;

   assign cell_ctl.ins_en = ins_en;
   assign cell_ctl.key    = op_key_ff;
   assign cell_ctl.child  = op_child_ff;

   // the row of cells, one per key slot
   for (genvar gi = 0; gi < MAX_KEYS_P; gi++) begin : g_cell
      bine_cell #(
         .CELL_IDX_P (gi),
         .CNT_W_P    (CNT_W)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl     (cell_ctl),
         .count   (key_total_ff),
         .nbr_in  (nbr_chain[gi]),
         .nbr_out (nbr_chain[gi+1]),
         .tok_in  (tok_chain[gi]),
         .tok_out (tok_chain[gi+1])
      );
   end

   // one operation in flight; the result register must be free or draining
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && rsp_free;
   assign req_accept     = req_chan.valid && req_chan.ready;

   // split read slot: idx_ff, seen through the chain element to its right
   assign rd_sel     = CNT_W'(idx_ff) + CNT_W'(1);
   assign split_last = rd_sel == key_total_ff;

   always_comb begin
      state_in     = state_ff;
      key_total_in = key_total_ff;
      child0_in    = child0_ff;
      op_key_in    = op_key_ff;
      op_child_in  = op_child_ff;
      start_in     = 1'b0;
      idx_in       = idx_ff;
      rsp_load     = 1'b0;
      rsp_next     = '0;
      ins_en       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_chan.payload.action)
                  ACT_CLEAR: begin
                     key_total_in  = '0;
                     rsp_load      = 1'b1;
                     rsp_next.last = 1'b1;
                  end
                  ACT_SET_LEFT: begin
                     child0_in     = req_chan.payload.child;
                     rsp_load      = 1'b1;
                     rsp_next.last = 1'b1;
                  end
                  ACT_FIND: begin
                     op_key_in = req_chan.payload.key;
                     start_in  = 1'b1;
                     state_in  = ST_FIND;
                  end
                  ACT_INSERT: begin
                     if (key_total_ff == FULL_CNT) begin
                        rsp_load        = 1'b1;
                        rsp_next.status = STS_FULL;
                        rsp_next.last   = 1'b1;
                     end else begin
                        op_key_in   = req_chan.payload.key;
                        op_child_in = req_chan.payload.child;
                        state_in    = ST_INS;
                     end
                  end
                  ACT_SPLIT: begin
                     if (key_total_ff == '0) begin
                        rsp_load        = 1'b1;
                        rsp_next.status = STS_EMPTY;
                        rsp_next.last   = 1'b1;
                     end else begin
                        // separator slot is count / 2
                        idx_in   = IDX_W'(key_total_ff >> 1);
                        state_in = ST_SPLIT;
                     end
                  end
                  default: begin
                     rsp_load      = 1'b1;
                     rsp_next.last = 1'b1;
                  end
               endcase
            end
         end
         ST_INS: begin
            // every cell at or right of the insert point shifts or takes the new entry together
            ins_en        = 1'b1;
            key_total_in  = key_total_ff + CNT_W'(1);
            rsp_load      = 1'b1;
            rsp_next.last = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_FIND: begin
            if (tok_chain[MAX_KEYS_P].valid) begin
               // no key above the probe in a full node: rightmost child
               rsp_next.child_out = tok_chain[MAX_KEYS_P].found ?
                                    tok_chain[MAX_KEYS_P].sel :
                                    nbr_chain[MAX_KEYS_P].child;
               rsp_next.last      = 1'b1;
               rsp_load           = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         ST_SPLIT: begin
            if (rsp_free) begin
               rsp_load           = 1'b1;
               rsp_next.key_out   = nbr_chain[rd_sel].key;
               rsp_next.child_out = nbr_chain[rd_sel].child;
               rsp_next.last      = split_last;
               idx_in             = idx_ff + IDX_W'(1);
               if (split_last) begin
                  key_total_in = key_total_ff >> 1;
                  state_in     = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result register parts the node from the consumer
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = rsp_next;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
         rsp_data_in  = rsp_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      child0_ff   <= child0_in;
      op_key_ff   <= op_key_in;
      op_child_ff <= op_child_in;
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         key_total_ff <= '0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         key_total_ff <= key_total_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

endmodule

@@ sim/bine_node_scoreboard.sv @@
// scoreboard for the b+ tree internal node engine: mirrors the node, predicts beats
// and compares every response beat against the oldest prediction
// depends on bine_pkg and bine_if

module bine_node_scoreboard
   import bine_pkg::*;
#(
   parameter int MAX_KEYS_P = 16
) (
   input  logic clock,
   input  logic reset,
   bine_req_if  req_mon,
   bine_rsp_if  rsp_mon,
   output int   error_count,
   output int   pending_count
);

   // private copy of the node
   logic [KEY_W-1:0]   node_key_copy   [MAX_KEYS_P];
   logic [CHILD_W-1:0] node_child_copy [MAX_KEYS_P+1];
   int                 node_key_count;

   rsp_payload_type beats_due [$];
   int              mismatches = 0;
   int              due_count  = 0;

   assign error_count   = mismatches;
   assign pending_count = due_count;

   task automatic report_mismatch(input string what);
      $display("mismatch @%0t: %s", $time, what);
      mismatches++;
   endtask

   function automatic rsp_payload_type rsp_beat(input status_type sts,
                                                input logic [CHILD_W-1:0] child,
                                                input logic [KEY_W-1:0] key,
                                                input logic last);
      rsp_payload_type b;
      b.status    = sts;
      b.child_out = child;
      b.key_out   = key;
      b.last      = last;
      return b;
   endfunction

   // works out the beats one request causes and updates the copy
   task automatic apply_node_op(input req_payload_type item);
      int                 pos;
      int                 mid;
      bit                 hit;
      logic [CHILD_W-1:0] sel;
      case (item.action)
         ACT_CLEAR: begin
            node_key_count = 0;
            beats_due.push_back(rsp_beat(STS_OK, '0, '0, 1'b1));
         end
         ACT_SET_LEFT: begin
            node_child_copy[0] = item.child;
            beats_due.push_back(rsp_beat(STS_OK, '0, '0, 1'b1));
         end
         ACT_FIND: begin
            // first key strictly above the probe picks the child on its left
            hit = 1'b0;
            sel = node_child_copy[node_key_count];
            for (int i = 0; i < node_key_count; i++) begin
               if (!hit && item.key < node_key_copy[i]) begin
                  hit = 1'b1;
                  sel = node_child_copy[i];
               end
            end
            beats_due.push_back(rsp_beat(STS_OK, sel, '0, 1'b1));
         end
         ACT_INSERT: begin
            if (node_key_count >= MAX_KEYS_P) begin
               beats_due.push_back(rsp_beat(STS_FULL, '0, '0, 1'b1));
            end else begin
               pos = 0;
               while (pos < node_key_count && node_key_copy[pos] < item.key) pos++;
               for (int i = node_key_count; i > pos; i--) begin
                  node_key_copy[i]     = node_key_copy[i-1];
                  node_child_copy[i+1] = node_child_copy[i];
               end
               node_key_copy[pos]     = item.key;
               node_child_copy[pos+1] = item.child;
               node_key_count++;
               beats_due.push_back(rsp_beat(STS_OK, '0, '0, 1'b1));
            end
         end
         ACT_SPLIT: begin
            if (node_key_count == 0) begin
               beats_due.push_back(rsp_beat(STS_EMPTY, '0, '0, 1'b1));
            end else begin
               // separator first, then the keys that move to the sibling
               mid = node_key_count / 2;
               for (int i = mid; i < node_key_count; i++) begin
                  beats_due.push_back(rsp_beat(STS_OK, node_child_copy[i+1],
                                               node_key_copy[i], i + 1 == node_key_count));
               end
               node_key_count = mid;
            end
         end
         default: begin
            beats_due.push_back(rsp_beat(STS_OK, '0, '0, 1'b1));
         end
      endcase
   endtask

   always @(posedge clock) begin : watch
      rsp_payload_type got;
      rsp_payload_type want;
      if (reset) begin
         beats_due.delete();
         node_key_count = 0;
      end else begin
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            got = rsp_mon.payload;
            if (beats_due.size() == 0) begin
               report_mismatch($sformatf("unexpected beat %h", got));
            end else begin
               want = beats_due.pop_front();
               if (got.status !== want.status)
                  report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
               if (got.child_out !== want.child_out)
                  report_mismatch($sformatf("child_out %h, want %h",
                                            got.child_out, want.child_out));
               if (got.key_out !== want.key_out)
                  report_mismatch($sformatf("key_out %h, want %h", got.key_out, want.key_out));
               if (got.last !== want.last)
                  report_mismatch($sformatf("last %b, want %b", got.last, want.last));
            end
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            apply_node_op(req_mon.payload);
         end
      end
      due_count = beats_due.size();
   end

endmodule

@@ sim/btree_internal_node_engine_unit_test.sv @@
// testbench top for the b+ tree internal node engine: clock, reset, request
// stimulus, response back-pressure and the verdict
// depends on bine_pkg, bine_if, bine_node_scoreboard and the engine itself

module btree_internal_node_engine_unit_test
   import bine_pkg::*;
();

   localparam int NODE_KEYS    = 16;
   // find is the slowest single beat; a full split adds one beat per cycle while the consumer keeps up
   localparam int LATENCY_TAIL = 2 * NODE_KEYS + 8;
   // generous: ~320 requests, up to 8 beats each, heavy stalls on both sides
   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_ITEMS  = 95;

   logic clock;
   logic reset;

   bine_req_if req_chan ();
   bine_rsp_if rsp_chan ();

   int error_count;
   int pending_count;

   // idle odds in percent, changed per phase
   int send_idle_pct = 23;
   int rcv_idle_pct  = 57;
   int cycle_count   = 0;

   // stimulus-side bookkeeping, only to keep requests legal and well shaped
   int               items_sent = 0;
   int               node_fill  = 0;
   bit               left_set   = 1'b0;
   logic [KEY_W-1:0] key_pool [$];

   btree_internal_node_engine_unit #(
      .MAX_KEYS_P (NODE_KEYS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   bine_node_scoreboard #(
      .MAX_KEYS_P (NODE_KEYS)
   ) scoreboard (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // response back-pressure: ready drops at random per cycle
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // keys: fresh random bits, repeats of keys already inserted, their
   // neighbors, tiny values and the two extremes
   function automatic logic [KEY_W-1:0] pick_key();
      int               roll;
      logic [KEY_W-1:0] k;
      roll = $urandom_range(99);
      k    = {$urandom, $urandom};
      if (key_pool.size() != 0 && roll < 30) begin
         k = key_pool[$urandom_range(key_pool.size() - 1)];
      end else if (key_pool.size() != 0 && roll < 45) begin
         k = key_pool[$urandom_range(key_pool.size() - 1)];
         k = $urandom_range(1) ? k + 64'd1 : k - 64'd1;
      end else if (roll < 55) begin
         k = 64'($urandom_range(15));
      end else if (roll < 60) begin
         k = $urandom_range(1) ? '1 : '0;
      end
      return k;
   endfunction

   function automatic logic [CHILD_W-1:0] pick_child();
      int roll;
      roll = $urandom_range(99);
      if (roll < 10) return '0;
      if (roll < 20) return '1;
      return $urandom;
   endfunction

   // one request beat; valid stays high into the next beat unless we idle
   task automatic send_item(input action_type act, input logic [KEY_W-1:0] key,
                            input logic [CHILD_W-1:0] child);
      req_payload_type p;
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      p.action = act;
      p.key    = key;
      p.child  = child;
      req_chan.valid   <= 1'b1;
      req_chan.payload <= p;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      items_sent++;
      case (act)
         ACT_CLEAR:    node_fill = 0;
         ACT_SET_LEFT: left_set = 1'b1;
         ACT_INSERT: begin
            if (node_fill < NODE_KEYS) begin
               node_fill++;
               key_pool.push_back(key);
               if (key_pool.size() > 32) void'(key_pool.pop_front());
            end
         end
         ACT_SPLIT:    node_fill = node_fill / 2;
         default: ;
      endcase
   endtask

   // hold off the sender until every predicted beat has come back
   task automatic wait_for_node_idle();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      @(posedge clock);
   endtask

   // occasional noise beat or a full drain in the middle of a session
   task automatic stir_node();
      action_type act;
      int         roll;
      roll = $urandom_range(99);
      if (roll < 10) begin
         act = action_type'($urandom_range(ACT_SPLIT));
         // never probe before the left child exists
         if (act == ACT_FIND && !left_set) act = ACT_SET_LEFT;
         send_item(act, pick_key(), pick_child());
      end else if (roll < 13) begin
         wait_for_node_idle();
      end
   endtask

   // a realistic run of work on one node: maybe clear, maybe set the left child,
   // fill to some level with finds in between, probe, then usually split
   task automatic run_node_session();
      int roll;
      int target;
      if ($urandom_range(1)) send_item(ACT_CLEAR, pick_key(), pick_child());
      if (!left_set || $urandom_range(99) < 30)
         send_item(ACT_SET_LEFT, pick_key(), pick_child());
      roll   = $urandom_range(99);
      target = (roll < 15) ? NODE_KEYS :
               (roll < 30) ? $urandom_range(3) : $urandom_range(NODE_KEYS, 1);
      while (node_fill < target) begin
         stir_node();
         if ($urandom_range(99) < 25) send_item(ACT_FIND, pick_key(), pick_child());
         send_item(ACT_INSERT, pick_key(), pick_child());
      end
      // a full node must refuse further inserts
      if (node_fill == NODE_KEYS) begin
         repeat ($urandom_range(2)) send_item(ACT_INSERT, pick_key(), pick_child());
      end
      repeat ($urandom_range(3, 1)) send_item(ACT_FIND, pick_key(), pick_child());
      if ($urandom_range(99) < 75) send_item(ACT_SPLIT, pick_key(), pick_child());
      if ($urandom_range(99) < 20) send_item(ACT_SPLIT, pick_key(), pick_child());
   endtask

   initial begin : stimulus
      int base;
      reset            <= 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.payload <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: split of an empty node is flagged
      send_item(ACT_SPLIT, '1, '1);
      send_item(ACT_SET_LEFT, '0, '1);
      // find on an empty node lands on the left child
      send_item(ACT_FIND, '0, '0);
      send_item(ACT_INSERT, '1, '1);
      send_item(ACT_INSERT, '0, '0);
      // equal key goes ahead of the one already there
      send_item(ACT_INSERT, '0, 32'h1234_5678);
      // probe equal to a key leads right
      send_item(ACT_FIND, '0, '0);
      send_item(ACT_FIND, '1, '0);
      // three keys: separator plus one moved key
      send_item(ACT_SPLIT, '0, '0);
      // clear a node that still holds a key
      send_item(ACT_CLEAR, '1, '1);
      // fill to the brim, get refused, split the full node into 8 beats
      repeat (NODE_KEYS) send_item(ACT_INSERT, pick_key(), pick_child());
      send_item(ACT_INSERT, '1, '1);
      send_item(ACT_SPLIT, '0, '0);

      // random sessions in three idle phases, drained between phases
      base = items_sent;
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 23; rcv_idle_pct = 57; end
            1: begin send_idle_pct = 57; rcv_idle_pct = 23; end
            default: begin send_idle_pct = 0; rcv_idle_pct = 0; end
         endcase
         while (items_sent < base + (phase + 1) * PHASE_ITEMS) run_node_session();
         wait_for_node_idle();
      end

      // let any stray beat show up before the verdict
      repeat (LATENCY_TAIL) @(posedge clock);
      @(negedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

@@ btree_internal_node_engine_unit.f @@
src/bine_pkg.sv
src/bine_if.sv
src/bine_cell.sv
src/btree_internal_node_engine_unit.sv
sim/bine_node_scoreboard.sv
sim/btree_internal_node_engine_unit_test.sv
